### src/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is asserted
`define RS_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that also holds while reset is asserted
`define RS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/rs108_pkg.sv
// Shared types, constants and GF(2^8) helpers for the RS(10,8) symbol corrector.
package rs108_pkg;

  // Codeword geometry
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned SYM_FIELDS  = 10;
  localparam int unsigned NUM_SYMBOLS = 10;  // symbols covered by the syndromes, at most 10
  localparam int unsigned TDATA_W     = SYM_FIELDS * SYM_W;

  // Field polynomial low byte after reset (x^8 + x^4 + x^3 + x^2 + 1)
  localparam logic [SYM_W-1:0] POLY_RESET = 8'h1D;

  typedef logic [SYM_W-1:0] sym_t;

  typedef enum logic [1:0] {
    STATUS_NONE          = 2'd0,
    STATUS_CORRECTED     = 2'd1,
    STATUS_UNCORRECTABLE = 2'd2
  } status_e;

  // Error locator results handed to the correction stage
  typedef struct packed {
    logic [NUM_SYMBOLS-1:0] match;  // S1 == S0 * alpha^j
    logic                   s0_zero;
    logic                   s1_zero;
  } rs108_loc_t;

  // Multiply by alpha: shift left, reduce by the polynomial if the top bit fell out
  function automatic sym_t gf_mul_alpha(sym_t v, sym_t poly);
    sym_t sh;
    sh = {v[SYM_W-2:0], 1'b0};
    return v[SYM_W-1] ? (sh ^ poly) : sh;
  endfunction

  // Multiply by alpha^k for a constant k below SYM_FIELDS
  function automatic sym_t gf_mul_alpha_pow(sym_t v, int unsigned k, sym_t poly);
    sym_t acc;
    acc = v;
    for (int unsigned t = 0; t < SYM_FIELDS - 1; t++) begin
      if (t < k) begin
        acc = gf_mul_alpha(acc, poly);
      end
    end
    return acc;
  endfunction

endpackage

### src/rs108_err_locate.sv
// Error locator: compares S1 against S0 * alpha^j for every codeword position.
module rs108_err_locate
  import rs108_pkg::*;
(
  input  sym_t       s0_i,
  input  sym_t       s1_i,
  input  sym_t       poly_i,
  output rs108_loc_t loc_o
);

  sym_t t_pow [NUM_SYMBOLS];

  // Successive powers of alpha times S0
  always_comb begin
    t_pow[0] = s0_i;
    for (int unsigned j = 1; j < NUM_SYMBOLS; j++) begin
      t_pow[j] = gf_mul_alpha(t_pow[j-1], poly_i);
    end
  end

  // Position compares and zero flags
  always_comb begin
    for (int unsigned j = 0; j < NUM_SYMBOLS; j++) begin
      loc_o.match[j] = (t_pow[j] == s1_i);
    end
    loc_o.s0_zero = (s0_i == '0);
    loc_o.s1_zero = (s1_i == '0);
  end

endmodule

### src/rs_10_8_symbol_corrector_core.sv
// Top level of the RS(10,8) single-symbol corrector over GF(2^8).
// Four register stages (weighting, syndromes, locator, correction), the last one the
// output register. Throughput: one codeword per cycle while the output is not stalled;
// each stage has its own valid bit and holds only while it and every stage after it are full.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets the field
// polynomial low byte to 0x1D.
module rs_10_8_symbol_corrector_core
  import rs108_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration: field polynomial low byte
  input  logic               cfg_we_i,
  input  logic [SYM_W-1:0]   cfg_wdata_i,
  // Codeword in
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // sym0 [7:0] .. sym9 [79:72]
  // Corrected codeword out
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // out_sym0 [7:0] .. out_sym9 [79:72]
  output logic [1:0]         m_axis_tuser    // status [1:0]
);

  // Configuration register
  sym_t poly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= POLY_RESET;
    end else if (cfg_we_i) begin
      poly_q <= cfg_wdata_i;
    end
  end

  // Stage valids and stall chain
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !out_valid_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1) v1_q        <= s_axis_tvalid;
      if (rdy2) v2_q        <= v1_q;
      if (rdy3) v3_q        <= v2_q;
      if (rdy4) out_valid_q <= v3_q;
    end
  end

  // Stage 1: unpack and weight each symbol by alpha^i
  sym_t sym_in [SYM_FIELDS];
  sym_t w_d    [NUM_SYMBOLS];
  sym_t sym1_q [SYM_FIELDS];
  sym_t w1_q   [NUM_SYMBOLS];

  always_comb begin
    for (int unsigned i = 0; i < SYM_FIELDS; i++) begin
      sym_in[i] = s_axis_tdata[i*SYM_W +: SYM_W];
    end
    for (int unsigned i = 0; i < NUM_SYMBOLS; i++) begin
      w_d[i] = gf_mul_alpha_pow(sym_in[i], i, poly_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      sym1_q <= sym_in;
      w1_q   <= w_d;
    end
  end

  // Stage 2: syndromes S0 and S1
  sym_t s0_d, s1_d;
  sym_t sym2_q [SYM_FIELDS];
  sym_t s0_2_q, s1_2_q;

  always_comb begin
    s0_d = '0;
    s1_d = '0;
    for (int unsigned i = 0; i < NUM_SYMBOLS; i++) begin
      s0_d = s0_d ^ sym1_q[i];
      s1_d = s1_d ^ w1_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      sym2_q <= sym1_q;
      s0_2_q <= s0_d;
      s1_2_q <= s1_d;
    end
  end

  // Stage 3: error location
  rs108_loc_t loc_d;
  rs108_loc_t loc3_q;
  sym_t       sym3_q [SYM_FIELDS];
  sym_t       s0_3_q;

  rs108_err_locate u_locate (
    .s0_i   (s0_2_q),
    .s1_i   (s1_2_q),
    .poly_i (poly_q),
    .loc_o  (loc_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      sym3_q <= sym2_q;
      s0_3_q <= s0_2_q;
      loc3_q <= loc_d;
    end
  end

  // Stage 4: pick the lowest matching position, correct it, set status
  sym_t    out_sym_d [SYM_FIELDS];
  status_e status_d;
  logic    found;
  sym_t    out_sym_q [SYM_FIELDS];
  status_e status_q;

  always_comb begin
    out_sym_d = sym3_q;
    found     = 1'b0;
    if (loc3_q.s0_zero && loc3_q.s1_zero) begin
      status_d = STATUS_NONE;
    end else if (loc3_q.s0_zero || loc3_q.s1_zero) begin
      status_d = STATUS_UNCORRECTABLE;
    end else begin
      for (int unsigned j = 0; j < NUM_SYMBOLS; j++) begin
        if (!found && loc3_q.match[j]) begin
          found        = 1'b1;
          out_sym_d[j] = sym3_q[j] ^ s0_3_q;
        end
      end
      status_d = found ? STATUS_CORRECTED : STATUS_UNCORRECTABLE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      out_sym_q <= out_sym_d;
      status_q  <= status_d;
    end
  end

  // Output packing
  always_comb begin
    for (int unsigned i = 0; i < SYM_FIELDS; i++) begin
      m_axis_tdata[i*SYM_W +: SYM_W] = out_sym_q[i];
    end
  end

  assign m_axis_tuser = status_q;

endmodule

### src/rs108_checker.sv
// Port-level checks for the RS(10,8) corrector, bound to the top level.
`include "assert_macros.svh"

module rs108_checker
  import rs108_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]         m_axis_tuser
);

  // pipeline must be empty while reset is held
  `RS_ASSERT_ALWAYS(a_empty_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid, "valid during reset")

  // a stalled result holds until taken
  `RS_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "stalled result changed")

  // input back-pressure only when every stage is full behind a stalled output
  `RS_ASSERT(a_backpressure, clk_i, rst_ni,
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

  // status code is one of the three defined codes
  `RS_ASSERT(a_status_code, clk_i, rst_ni,
    m_axis_tvalid |-> m_axis_tuser == STATUS_NONE || m_axis_tuser == STATUS_CORRECTED ||
      m_axis_tuser == STATUS_UNCORRECTABLE,
    "undefined status code")

endmodule

bind rs_10_8_symbol_corrector_core rs108_checker u_rs108_checker (.*);
